// ===== src/ffsa_pkg.sv =====
package ffsa_pkg;

  // Item codes carried in the input tuser field
  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_RESCAN = 2'd3
  } act_t;

  localparam int DEF_SLOTS = 64;

  // Field widths on the channels
  localparam int ACT_W    = 2;
  localparam int SLOT_FW  = 6;
  localparam int STAT_W   = 8;
  localparam int COUNT_W  = 7;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 24;

  // One occupancy memory row holds this many slots
  localparam int ROW_BITS  = 64;
  localparam int ROW_IDX_W = $clog2(ROW_BITS);

  // Lowest set bit of a row (0 when none is set)
  function automatic logic [ROW_IDX_W-1:0] first_one(input logic [ROW_BITS-1:0] v);
    logic [ROW_IDX_W-1:0] idx;
    idx = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = ROW_IDX_W'(i);
    end
    return idx;
  endfunction

  // Highest set bit of a row (0 when none is set)
  function automatic logic [ROW_IDX_W-1:0] last_one(input logic [ROW_BITS-1:0] v);
    logic [ROW_IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < ROW_BITS; i++) begin
      if (v[i]) idx = ROW_IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== src/first_free_slot_allocator.sv =====
// First-fit slot allocator with a low-free hint.
// Input channel in_*: in_tuser carries the item code (allocate, write slot
// status, clear all, rescan); in_tdata carries the target slot, the status
// byte and the pool-enable flag. Every item returns exactly one word on
// out_*: out_tuser is the grant flag, out_tdata the granted slot and the
// hint and bound after the item.
// Only the zero/nonzero state of each status byte is observable, so the
// table is kept as an occupancy memory of ROW_BITS-slot rows, read one row
// per cycle through one registered read port and written back on a grant
// or a status write. One item is in flight at a time; in_tready is high only
// while the block waits for an item. An allocate visits 1 to ROWS+1 rows and
// an enabled rescan reads all ROWS rows, where ROWS = ceil(SLOTS/ROW_BITS);
// clear, disabled rescan and out-of-range writes read no row.
// A finished word waits in the output register while out_tready is low;
// new items are still taken, but the next result waits until it drains.
// Reset (synchronous, rst_n low) marks every row invalid, so all slots
// read as free at once with no clearing pass, and zeroes hint and bound.
module first_free_slot_allocator #(
  parameter int SLOTS = ffsa_pkg::DEF_SLOTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [5:0] target_slot, [13:6] status_value, [14] pool_enabled, [15] zero
  input  logic [ffsa_pkg::IN_W-1:0]   in_tdata,
  // [1:0] action
  input  logic [ffsa_pkg::ACT_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [5:0] granted_slot, [12:6] hint_after, [19:13] bound_after, [23:20] zero
  output logic [ffsa_pkg::OUT_W-1:0]  out_tdata,
  // [0] granted
  output logic                        out_tuser
);
  import ffsa_pkg::*;

  localparam int ROWS = (SLOTS + ROW_BITS - 1) / ROW_BITS;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = ROW_IDX_W;
  localparam int XW   = RW + CW + 1;
  localparam int HW   = $clog2(SLOTS + 1);
  localparam int VW   = $clog2(ROWS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                state_r;
  logic [CW-1:0]         tgt_col_r;
  logic                  status_nz_r;
  logic [CW-1:0]         sc_r;
  logic [RW-1:0]         cur_row_r;
  logic [VW-1:0]         visit_r;
  logic [HW-1:0]         hint_r;
  logic [HW-1:0]         bound_r;
  logic                  scan_found_r;
  logic                  res_granted_r;
  logic [SLOT_FW-1:0]    res_slot_r;
  logic [ROWS-1:0]       row_vld_r;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_tdata_r;
  logic                  out_tuser_r;

  // Occupancy memory and its registered read port
  logic [ROW_BITS-1:0]   mem [ROWS];
  logic [ROW_BITS-1:0]   rd_data_r;
  logic                  rd_vld_r;

  logic                  rd_en;
  logic [RW-1:0]         rd_addr;
  logic                  mem_we;
  logic [ROW_BITS-1:0]   wr_data;

  logic                  in_fire;
  act_t                  in_act;
  logic [SLOT_FW-1:0]    in_target;
  logic [STAT_W-1:0]     in_status;
  logic                  in_enable;
  logic [XW-1:0]         tgt_x;
  logic                  tgt_ok;
  logic [XW-1:0]         start_x;
  logic [RW-1:0]         next_row;
  logic [ROW_BITS-1:0]   occ;
  logic [ROW_BITS-1:0]   rng;
  logic [ROW_BITS-1:0]   lo_mask;
  logic [ROW_BITS-1:0]   free_vec;
  logic [ROW_BITS-1:0]   used_vec;
  logic                  free_any;
  logic                  used_any;
  logic [CW-1:0]         free_col;
  logic [CW-1:0]         last_col;
  logic [XW-1:0]         free_x;
  logic [XW-1:0]         free_p1;
  logic [XW-1:0]         used_p1;
  logic                  last_visit;
  logic                  out_free;

  // Unpack the input word
  assign in_fire   = in_tvalid && in_tready;
  assign in_act    = act_t'(in_tuser);
  assign in_target = in_tdata[SLOT_FW-1:0];
  assign in_status = in_tdata[SLOT_FW +: STAT_W];
  assign in_enable = in_tdata[SLOT_FW + STAT_W];

  assign tgt_x   = XW'(in_target);
  assign tgt_ok  = tgt_x < XW'(SLOTS);
  // A hint at or past the end restarts the search at slot 0
  assign start_x = (hint_r < HW'(SLOTS)) ? XW'(hint_r) : '0;

  assign next_row   = (cur_row_r == RW'(ROWS - 1)) ? '0 : cur_row_r + 1'b1;
  assign last_visit = (visit_r == VW'(ROWS));

  // Decode the row under inspection; an invalid row reads as all free
  always_comb begin
    occ = rd_vld_r ? rd_data_r : '0;
    for (int c = 0; c < ROW_BITS; c++) begin
      rng[c]     = XW'({cur_row_r, CW'(c)}) < XW'(SLOTS);
      lo_mask[c] = CW'(c) >= sc_r;
    end
    free_vec = ~occ & rng;
    if (state_r == ST_SEARCH && visit_r == '0) begin
      free_vec = free_vec & lo_mask;
    end
    used_vec = occ & rng;
  end

  assign free_any = |free_vec;
  assign used_any = |used_vec;
  assign free_col = first_one(free_vec);
  assign last_col = last_one(used_vec);
  assign free_x   = XW'({cur_row_r, free_col});
  assign free_p1  = free_x + 1'b1;
  assign used_p1  = XW'({cur_row_r, last_col}) + 1'b1;

  // Drive the memory port: read the next row or write back the modified one
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    mem_we  = 1'b0;
    wr_data = occ;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_act)
            ACT_ALLOC: begin
              rd_en   = 1'b1;
              rd_addr = start_x[CW +: RW];
            end
            ACT_WRITE: begin
              rd_en   = tgt_ok;
              rd_addr = tgt_x[CW +: RW];
            end
            ACT_RESCAN: begin
              rd_en   = in_enable;
              rd_addr = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (free_any) begin
          mem_we  = 1'b1;
          wr_data = occ | (ROW_BITS'(status_nz_r) << free_col);
        end else if (!last_visit) begin
          rd_en   = 1'b1;
          rd_addr = next_row;
        end
      end
      ST_WRITE: begin
        mem_we  = 1'b1;
        wr_data = (occ & ~(ROW_BITS'(1) << tgt_col_r)) |
                  (ROW_BITS'(status_nz_r) << tgt_col_r);
      end
      ST_SCAN: begin
        if (cur_row_r != RW'(ROWS - 1)) begin
          rd_en   = 1'b1;
          rd_addr = next_row;
        end
      end
      default: ;
    endcase
  end

  // Memory array with registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_row_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
  end

  assign out_free = !out_valid_r || out_tready;

  // Sequencer, hint and bound, and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hint_r      <= '0;
      bound_r     <= '0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the drained word unless a new one replaces it below
      if (out_valid_r && out_tready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            status_nz_r   <= |in_status;
            tgt_col_r     <= tgt_x[CW-1:0];
            res_granted_r <= 1'b0;
            res_slot_r    <= '0;
            case (in_act)
              ACT_ALLOC: begin
                cur_row_r <= start_x[CW +: RW];
                sc_r      <= start_x[CW-1:0];
                visit_r   <= '0;
                state_r   <= ST_SEARCH;
              end
              ACT_WRITE: begin
                cur_row_r <= tgt_x[CW +: RW];
                state_r   <= tgt_ok ? ST_WRITE : ST_DONE;
              end
              ACT_CLEAR: begin
                row_vld_r <= '0;
                hint_r    <= '0;
                bound_r   <= '0;
                state_r   <= ST_DONE;
              end
              default: begin
                hint_r       <= '0;
                bound_r      <= '0;
                scan_found_r <= 1'b0;
                cur_row_r    <= '0;
                state_r      <= in_enable ? ST_SCAN : ST_DONE;
              end
            endcase
          end
        end
        ST_SEARCH: begin
          if (free_any) begin
            row_vld_r[cur_row_r] <= 1'b1;
            hint_r               <= HW'(free_p1);
            if (bound_r < HW'(free_p1)) begin
              bound_r <= HW'(free_p1);
            end
            res_granted_r <= 1'b1;
            res_slot_r    <= free_x[SLOT_FW-1:0];
            state_r       <= ST_DONE;
          end else if (last_visit) begin
            state_r <= ST_DONE;
          end else begin
            cur_row_r <= next_row;
            visit_r   <= visit_r + 1'b1;
          end
        end
        ST_WRITE: begin
          row_vld_r[cur_row_r] <= 1'b1;
          state_r              <= ST_DONE;
        end
        ST_SCAN: begin
          if (!scan_found_r && free_any) begin
            hint_r       <= HW'(free_x);
            scan_found_r <= 1'b1;
          end
          if (used_any) begin
            bound_r <= HW'(used_p1);
          end
          if (cur_row_r == RW'(ROWS - 1)) begin
            state_r <= ST_DONE;
          end else begin
            cur_row_r <= next_row;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_tuser_r <= res_granted_r;
            out_tdata_r <= {(OUT_W - SLOT_FW - 2 * COUNT_W)'(0), COUNT_W'(bound_r),
                            COUNT_W'(hint_r), res_slot_r};
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // A new result word only comes out of the completion state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside completion state");

  // A failed or non-allocate item reports slot zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tuser_r) |-> (out_tdata_r[SLOT_FW-1:0] == '0))
    else $error("slot reported without a grant");

  // Hint and bound never pass the table size
  assert property (@(posedge clk) disable iff (!rst_n)
    (hint_r <= HW'(SLOTS)) && (bound_r <= HW'(SLOTS)))
    else $error("hint or bound beyond table");

  // Write-back and row read never overlap in one cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && rd_en))
    else $error("memory read and write-back in the same cycle");

  // Search visits at most every row once plus the start row again
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (visit_r <= VW'(ROWS)))
    else $error("search ran past the last row");

endmodule
